// ===== src/infix_expression_evaluator_defines.svh =====
// assertion macros for the infix expression evaluator
// depends on: clk and rst_n in the scope of each use

`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IEE_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IEE_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/iee_pkg.sv =====
// shared types and constants for the infix expression evaluator
// used by iee_muldiv, infix_expression_evaluator and the testbench; no dependencies

package iee_pkg;

    localparam int VALUE_WIDTH  = 64;
    localparam int RESULT_WIDTH = 64;
    localparam int CNT_W        = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] word_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQUAL = 8'h3D;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2
    } term_op_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       line_end;
    } iee_in_t;

    typedef struct packed {
        logic signed [RESULT_WIDTH-1:0] value;
        logic                           divide_error;
    } iee_out_t;

    // request to the shared multiply/divide unit
    typedef struct packed {
        logic  start;
        logic  is_div;
        word_t a;
        word_t b;
    } muldiv_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } muldiv_rsp_t;

endpackage

// ===== src/iee_muldiv.sv =====
// iterative multiply / signed divide unit, one bit per cycle
// depends on: iee_pkg

module iee_muldiv (
    input  logic                clk,
    input  logic                rst_n,
    input  iee_pkg::muldiv_req_t req,
    output iee_pkg::muldiv_rsp_t rsp
);
    import iee_pkg::*;

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_FIX
    } unit_state_t;

    unit_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    word_t                  x_reg, x_next;
    word_t                  y_reg, y_next;
    word_t                  acc_reg, acc_next;
    logic                   div_reg, div_next;
    logic                   neg_reg, neg_next;
    logic                   done_reg, done_next;
    word_t                  result_reg, result_next;

    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   rem_diff;

    always_comb
    begin
        rem_shift = {acc_reg, x_reg[VALUE_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, y_reg};
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        div_next    = div_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    div_next = req.is_div;
                    acc_next = '0;
                    cnt_next = CNT_W'(VALUE_WIDTH - 1);
                    if (req.is_div)
                    begin
                        // divide magnitudes, fix the sign at the end
                        x_next   = req.a[VALUE_WIDTH-1] ? word_t'('0 - req.a) : req.a;
                        y_next   = req.b[VALUE_WIDTH-1] ? word_t'('0 - req.b) : req.b;
                        neg_next = req.a[VALUE_WIDTH-1] ^ req.b[VALUE_WIDTH-1];
                    end
                    else
                    begin
                        x_next   = req.a;
                        y_next   = req.b;
                        neg_next = 1'b0;
                    end
                    state_next = U_RUN;
                end
            end

            U_RUN:
            begin
                if (div_reg)
                begin
                    if (!rem_diff[VALUE_WIDTH])
                    begin
                        acc_next = rem_diff[VALUE_WIDTH-1:0];
                        x_next   = {x_reg[VALUE_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_shift[VALUE_WIDTH-1:0];
                        x_next   = {x_reg[VALUE_WIDTH-2:0], 1'b0};
                    end
                end
                else
                begin
                    if (y_reg[0])
                        acc_next = acc_reg + x_reg;
                    x_next = {x_reg[VALUE_WIDTH-2:0], 1'b0};
                    y_next = {1'b0, y_reg[VALUE_WIDTH-1:1]};
                end
                if (cnt_reg == '0)
                    state_next = U_FIX;
                else
                    cnt_next = cnt_reg - 1'b1;
            end

            U_FIX:
            begin
                if (div_reg)
                    result_next = neg_reg ? word_t'('0 - x_reg) : x_reg;
                else
                    result_next = acc_reg;
                done_next  = 1'b1;
                state_next = U_IDLE;
            end

            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            cnt_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            acc_reg    <= '0;
            div_reg    <= 1'b0;
            neg_reg    <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            acc_reg    <= acc_next;
            div_reg    <= div_next;
            neg_reg    <= neg_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

// ===== src/infix_expression_evaluator.sv =====
// top level of the streaming infix expression evaluator
// depends on: iee_pkg, iee_muldiv, infix_expression_evaluator_defines.svh

// One ASCII character per transaction on char_*; a result transaction on
// result_* for '=' or for a line end without an earlier '='. After a digit,
// a space, an operator that needs no multiply or divide, or a division by
// zero, the next character is accepted once S_FIN and S_APPLY have passed.
// A character that ends a number behind a * or behind a / with a nonzero
// divisor runs the shared shift-add multiply / restoring divide unit, one
// bit per cycle, and the block waits in S_WAIT for its result before
// S_APPLY and the next accept. A result waits in an output register, so a
// stalled result_ready only holds the block when a second result is due.
// Values wrap at VALUE_WIDTH bits and come out sign-extended; a division by
// zero sets the term to 0 and divide_error.

`include "infix_expression_evaluator_defines.svh"

module infix_expression_evaluator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  iee_pkg::iee_in_t  char_data,
    output logic              result_valid,
    input  logic              result_ready,
    output iee_pkg::iee_out_t result_data
);
    import iee_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIN,
        S_WAIT,
        S_APPLY
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  sym_reg, sym_next;
    logic        last_reg, last_next;
    logic        fin_req_reg, fin_req_next;
    word_t       total_reg, total_next;
    word_t       term_reg, term_next;
    word_t       number_reg, number_next;
    logic        in_number_reg, in_number_next;
    logic        subtract_reg, subtract_next;
    term_op_t    term_op_reg, term_op_next;
    logic        finished_reg, finished_next;
    logic        zdiv_reg, zdiv_next;
    iee_out_t    out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    muldiv_req_t md_req;
    muldiv_rsp_t md_rsp;

    logic        in_digit;
    logic        sym_digit;
    logic        active;
    logic        emit;
    logic        out_free;
    logic        apply_done;
    word_t       fold_val;
    logic [3:0]  digit_val;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    iee_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        in_digit   = is_digit(char_data.symbol);
        digit_val  = 4'(char_data.symbol - CH_ZERO);
        sym_digit  = is_digit(sym_reg);
        active     = !finished_reg && (sym_reg != CH_SPACE) && !sym_digit;
        emit       = (active && (sym_reg == CH_EQUAL)) || (last_reg && !finished_reg);
        out_free   = !out_valid_reg || result_ready;
        apply_done = (state_reg == S_APPLY) && (!emit || out_free);
        fold_val   = subtract_reg ? (total_reg - term_reg) : (total_reg + term_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        fin_req_next   = fin_req_reg;
        total_next     = total_reg;
        term_next      = term_reg;
        number_next    = number_reg;
        in_number_next = in_number_reg;
        subtract_next  = subtract_reg;
        term_op_next   = term_op_reg;
        finished_next  = finished_reg;
        zdiv_next      = zdiv_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        md_req.start   = 1'b0;
        md_req.is_div  = (term_op_reg == OP_DIV);
        md_req.a       = term_reg;
        md_req.b       = number_reg;

        if (result_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (char_valid)
                begin
                    sym_next     = char_data.symbol;
                    last_next    = char_data.line_end;
                    // a non-digit other than a space, or the line end, closes a pending number
                    fin_req_next = !finished_reg &&
                                   (((char_data.symbol != CH_SPACE) && !in_digit) ||
                                    char_data.line_end);
                    if (!finished_reg && in_digit)
                    begin
                        number_next    = word_t'(number_reg << 3) + word_t'(number_reg << 1)
                                         + word_t'(digit_val);
                        in_number_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                state_next = S_APPLY;
                if (fin_req_reg && in_number_reg)
                begin
                    case (term_op_reg)
                        OP_MUL:
                        begin
                            md_req.start = 1'b1;
                            state_next   = S_WAIT;
                        end
                        OP_DIV:
                        begin
                            if (number_reg == '0)
                            begin
                                term_next      = '0;
                                zdiv_next      = 1'b1;
                                number_next    = '0;
                                in_number_next = 1'b0;
                            end
                            else
                            begin
                                md_req.start = 1'b1;
                                state_next   = S_WAIT;
                            end
                        end
                        default:
                        begin
                            term_next      = term_reg + number_reg;
                            number_next    = '0;
                            in_number_next = 1'b0;
                        end
                    endcase
                end
            end

            S_WAIT:
            begin
                if (md_rsp.done)
                begin
                    term_next      = md_rsp.result;
                    number_next    = '0;
                    in_number_next = 1'b0;
                    state_next     = S_APPLY;
                end
            end

            S_APPLY:
            begin
                // hold here while an earlier result still blocks the output
                if (apply_done)
                begin
                    if (active)
                    begin
                        if ((sym_reg == CH_PLUS) || (sym_reg == CH_MINUS))
                        begin
                            total_next    = fold_val;
                            term_next     = '0;
                            term_op_next  = OP_ADD;
                            subtract_next = (sym_reg == CH_MINUS);
                        end
                        else if (sym_reg == CH_STAR)
                            term_op_next = OP_MUL;
                        else if (sym_reg == CH_SLASH)
                            term_op_next = OP_DIV;
                        else if (sym_reg == CH_EQUAL)
                            finished_next = 1'b1;
                    end
                    if (emit)
                    begin
                        out_next.value        = RESULT_WIDTH'($signed(fold_val));
                        out_next.divide_error = zdiv_reg;
                        out_valid_next        = 1'b1;
                    end
                    if (last_reg)
                    begin
                        total_next     = '0;
                        term_next      = '0;
                        number_next    = '0;
                        in_number_next = 1'b0;
                        subtract_next  = 1'b0;
                        term_op_next   = OP_ADD;
                        finished_next  = 1'b0;
                        zdiv_next      = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sym_reg       <= '0;
            last_reg      <= 1'b0;
            fin_req_reg   <= 1'b0;
            total_reg     <= '0;
            term_reg      <= '0;
            number_reg    <= '0;
            in_number_reg <= 1'b0;
            subtract_reg  <= 1'b0;
            term_op_reg   <= OP_ADD;
            finished_reg  <= 1'b0;
            zdiv_reg      <= 1'b0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sym_reg       <= sym_next;
            last_reg      <= last_next;
            fin_req_reg   <= fin_req_next;
            total_reg     <= total_next;
            term_reg      <= term_next;
            number_reg    <= number_next;
            in_number_reg <= in_number_next;
            subtract_reg  <= subtract_next;
            term_op_reg   <= term_op_next;
            finished_reg  <= finished_next;
            zdiv_reg      <= zdiv_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign char_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    `IEE_ASSERT_NEXT(a_accept_then_busy, char_valid && char_ready, !char_ready,
                     "char_ready stayed high after an accept")
    `IEE_ASSERT_IMP(a_done_only_waiting, md_rsp.done, state_reg == S_WAIT,
                    "muldiv result arrived outside the wait state")
    `IEE_ASSERT_NEXT(a_line_end_clears, apply_done && last_reg,
                     (total_reg == '0) && !finished_reg && !zdiv_reg && !in_number_reg,
                     "state not cleared after line end")

endmodule

// ===== dv/tb_infix_expression_evaluator.sv =====
// testbench for the infix expression evaluator: character stream in, checked results out
// depends on: iee_pkg and the infix_expression_evaluator rtl

module tb_infix_expression_evaluator;

    import iee_pkg::*;

    localparam int RANDOM_CHARS = 800;
    localparam int QUIET_TAIL   = 120;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        iee_in_t item;
        bit      drain;
    } pending_char_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     char_valid = 1'b0;
    logic     char_ready;
    iee_in_t  char_data = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    iee_out_t result_data;

    pending_char_t pending_chars[$];
    iee_out_t      due_results[$];

    // running copy of the evaluator state
    word_t    sum_total;
    word_t    cur_term;
    word_t    digits_value;
    bit       gathering;
    bit       minus_pending;
    term_op_t pending_op;
    bit       line_done;
    bit       div0_flag;

    int mismatches = 0;
    int chars_taken = 0;
    int results_taken = 0;
    int send_gap = 0;
    int take_gap = 0;
    int send_pct = 20;
    int take_pct = 20;

    infix_expression_evaluator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_data (result_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_state();
        sum_total     = '0;
        cur_term      = '0;
        digits_value  = '0;
        gathering     = 1'b0;
        minus_pending = 1'b0;
        pending_op    = OP_ADD;
        line_done     = 1'b0;
        div0_flag     = 1'b0;
    endfunction

    // signed quotient via magnitudes, truncating toward zero
    function automatic word_t trunc_div(word_t a, word_t b);
        word_t ma;
        word_t mb;
        word_t q;
        bit    na;
        bit    nb;
        na = a[VALUE_WIDTH-1];
        nb = b[VALUE_WIDTH-1];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        q  = ma / mb;
        if (na != nb)
            q = -q;
        return q;
    endfunction

    function automatic void close_number();
        if (!gathering)
            return;
        case (pending_op)
            OP_MUL: cur_term = cur_term * digits_value;
            OP_DIV:
            begin
                if (digits_value == '0)
                begin
                    cur_term  = '0;
                    div0_flag = 1'b1;
                end
                else
                    cur_term = trunc_div(cur_term, digits_value);
            end
            default: cur_term = cur_term + digits_value;
        endcase
        digits_value = '0;
        gathering    = 1'b0;
    endfunction

    function automatic iee_out_t line_result();
        iee_out_t r;
        word_t    v;
        v = minus_pending ? sum_total - cur_term : sum_total + cur_term;
        r.value        = $signed(v);
        r.divide_error = div0_flag;
        return r;
    endfunction

    function automatic void evaluate_symbol(iee_in_t item);
        bit       have;
        iee_out_t r;
        have = 1'b0;
        r    = '0;
        if (!line_done && item.symbol != CH_SPACE)
        begin
            if (item.symbol >= CH_ZERO && item.symbol <= CH_NINE)
            begin
                digits_value = digits_value * 10 + (item.symbol - CH_ZERO);
                gathering    = 1'b1;
            end
            else
            begin
                close_number();
                if (item.symbol == CH_PLUS || item.symbol == CH_MINUS)
                begin
                    sum_total     = minus_pending ? sum_total - cur_term
                                                  : sum_total + cur_term;
                    cur_term      = '0;
                    pending_op    = OP_ADD;
                    minus_pending = (item.symbol == CH_MINUS);
                end
                else if (item.symbol == CH_STAR)
                    pending_op = OP_MUL;
                else if (item.symbol == CH_SLASH)
                    pending_op = OP_DIV;
                else if (item.symbol == CH_EQUAL)
                begin
                    r         = line_result();
                    have      = 1'b1;
                    line_done = 1'b1;
                end
            end
        end
        if (item.line_end)
        begin
            if (!line_done)
            begin
                close_number();
                r    = line_result();
                have = 1'b1;
            end
            clear_state();
        end
        if (have)
            due_results.push_back(r);
    endfunction

    function automatic void push_char(logic [7:0] sym, bit last, bit drain);
        pending_char_t p;
        p.item.symbol   = sym;
        p.item.line_end = last;
        p.drain         = drain;
        pending_chars.push_back(p);
    endfunction

    function automatic void push_line(string s, bit drain);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1, drain && i == 0);
    endfunction

    function automatic string one_of(string a, string b);
        return ($urandom_range(0, 1) != 0) ? a : b;
    endfunction

    function automatic string spacer();
        return ($urandom_range(0, 5) == 0) ? " " : "";
    endfunction

    // mostly short numbers; now and then a wrapping one or a zero divisor
    function automatic string number_text();
        word_t w;
        string s;
        int    k;
        k = $urandom_range(0, 19);
        if (k == 0)
            s = "0";
        else if (k == 1)
            s = "9223372036854775808";
        else if (k == 2)
            s = "18446744073709551615";
        else if (k == 3)
        begin
            w = {$urandom, $urandom};
            s = $sformatf("%0d", w);
        end
        else
            s = $sformatf("%0d", $urandom_range(1, 999));
        if (s.len() > 1 && $urandom_range(0, 9) == 0)
            s = {s.substr(0, 0), " ", s.substr(1, s.len() - 1)};
        return s;
    endfunction

    function automatic void add_random_line();
        string s;
        int    terms;
        int    factors;
        int    n;
        bit    drain;
        drain = ($urandom_range(0, 39) == 0);
        // raw byte noise, including broken lines
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                push_char(8'($urandom_range(0, 255)), i == n - 1, drain && i == 0);
            return;
        end
        s = "";
        if ($urandom_range(0, 7) == 0)
            s = one_of("+", "-");
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++)
        begin
            if (t > 0)
                s = {s, spacer(), one_of("+", "-"), spacer()};
            s = {s, number_text()};
            factors = $urandom_range(0, 2);
            for (int f = 0; f < factors; f++)
                s = {s, spacer(), one_of("*", "/"), spacer(), number_text()};
        end
        if ($urandom_range(0, 15) == 0)
            s = {s, one_of("*", "-")};
        if ($urandom_range(0, 9) < 7)
        begin
            s = {s, "="};
            if ($urandom_range(0, 3) == 0)
                s = {s, "12+3=7"};
        end
        push_line(s, drain);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    // driver: one character transaction at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        pending_char_t head;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_data  <= '0;
            send_gap   <= 0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                evaluate_symbol(char_data);
                chars_taken++;
                if (chars_taken % 100 == 0)
                    send_pct = pick_pct();
            end
            if (!char_valid || char_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap   <= send_gap - 1;
                    char_valid <= 1'b0;
                end
                else if (pending_chars.size() != 0 &&
                         !(pending_chars[0].drain && due_results.size() != 0))
                begin
                    head = pending_chars.pop_front();
                    char_valid <= 1'b1;
                    char_data  <= head.item;
                    if (pending_chars.size() > QUIET_TAIL &&
                        $urandom_range(0, 99) < send_pct)
                        send_gap <= $urandom_range(1, 16);
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        iee_out_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            take_gap     <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_taken++;
                if (results_taken % 8 == 0)
                    take_pct = pick_pct();
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with none expected: value %0d divide_error %0b",
                             $time, result_data.value, result_data.divide_error);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_data.value !== want.value)
                    begin
                        $display("%0t: value mismatch: expected %0d actual %0d",
                                 $time, want.value, result_data.value);
                        mismatches++;
                    end
                    if (result_data.divide_error !== want.divide_error)
                    begin
                        $display("%0t: divide_error mismatch: expected %0b actual %0b",
                                 $time, want.divide_error, result_data.divide_error);
                        mismatches++;
                    end
                end
            end
            if (take_gap != 0)
            begin
                take_gap     <= take_gap - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (pending_chars.size() > QUIET_TAIL && $urandom_range(0, 99) < take_pct)
                    take_gap <= $urandom_range(1, 16);
            end
        end
    end

    initial
    begin
        clear_state();
        // empty line on a nul byte
        push_char(8'h00, 1'b1, 1'b0);
        // zero divisor with junk after the result, then an empty line on 0xff
        push_line("7/0=5", 1'b0);
        push_char(8'hFF, 1'b1, 1'b0);
        // digits joined over a space, precedence, line end without '='
        push_line("1 2*3-9/2+1", 1'b0);
        // the pipe drains before this line, which has a leading operator
        push_line("-8=", 1'b1);
        // unknown character ends a number
        push_line("3a4=", 1'b0);
        while (pending_chars.size() < RANDOM_CHARS + 25)
            add_random_line();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || char_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/iee_pkg.sv
src/iee_muldiv.sv
src/infix_expression_evaluator.sv
dv/tb_infix_expression_evaluator.sv
